// ----- src/tsm_pkg.sv -----
// Shared opcodes, status codes, entry type tags and entry layout for the typed stack machine.
package tsm_pkg;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_PUSH  = 3'd1;
    localparam logic [2:0] OP_POP   = 3'd2;
    localparam logic [2:0] OP_SAVE  = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;
    localparam logic [2:0] OP_ADD   = 3'd5;
    localparam logic [2:0] OP_SUB   = 3'd6;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_INDEX  = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_HALTED = 3'd4;

    localparam logic [1:0] IMM_INT = 2'd1;
    localparam logic [1:0] IMM_DEC = 2'd2;

    localparam logic [1:0] TY_EMPTY = 2'd0;
    localparam logic [1:0] TY_INT   = 2'd2;
    localparam logic [1:0] TY_DEC   = 2'd3;

    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

    localparam int ENTRY_W = 34;

    typedef struct packed {
        logic [1:0]  ty;
        logic [31:0] value;
    } t_entry;

endpackage

// ----- src/typed_two_stack_machine_top.sv -----
// Top level of the typed two-stack machine: control sequencer around two stack memories.
//
// Each input item is one instruction; the block answers every item with exactly one result
// item carrying the status, the operand stack top and both stack depths. Both stacks live in
// synchronous RAMs with a registered read; the operand top is also held in a register. When an
// item is accepted the RAMs are read at the slot below the operand top and at the requested
// data stack depth, and the item executes in the following cycle. A float add or subtract
// loads the register between the two adder stages and completes in a further state, and an
// add or subtract on mismatched types, which pops two entries, reads the new top back from
// the operand RAM in a further state. The next item is taken as soon as the sequencer is
// idle, even while the last result still waits in the output register; a result that
// cannot be handed over holds the sequencer in place.
// Any error sets a sticky halt, after which every item answers with the halted status.
module typed_two_stack_machine_top
    import tsm_pkg::*;
#(
    parameter int OPERAND_DEPTH = 64,
    parameter int DATA_DEPTH    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // imm_value[31:0]
    input  logic [4:0]  i_s_tuser,   // kind[2:0], imm_type[4:3]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // status[2:0], top_value[34:3], operand_count[41:35],
                                     // data_count[48:42], zero fill[55:49]
    output logic [1:0]  o_m_tuser    // top_type[1:0]
);

    localparam int OPW = $clog2(OPERAND_DEPTH + 1);
    localparam int OAW = $clog2(OPERAND_DEPTH);
    localparam int DPW = $clog2(DATA_DEPTH + 1);
    localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_FP     = 4'b0100,
        S_RELOAD = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_kind;
    logic [1:0] r_itype;
    logic [31:0] r_ival;
    logic [OPW-1:0] r_optr, n_optr;
    logic [DPW-1:0] r_dptr, n_dptr;
    logic       r_halt, n_halt;
    t_entry     r_top, n_top;

    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [1:0]  r_out_type;
    logic [31:0] r_out_value;
    logic [6:0]  r_out_ocnt, r_out_dcnt;

    logic       accept, out_free, done;
    logic [2:0] n_status;

    // Operand stack RAM port signals.
    logic           op_we, op_re;
    logic [OAW-1:0] op_waddr, op_raddr;
    t_entry         op_wdata, op_rdata;
    // Data stack RAM port signals.
    logic           dm_we, dm_re;
    logic [DAW-1:0] dm_waddr, dm_raddr;
    t_entry         dm_rdata;

    logic [OPW-1:0] optr_m1, optr_m2, optr_m3;
    logic [31:0]    d_idx;
    logic [31:0]    int_res;
    logic [31:0]    fp_sum;
    logic           fp_load;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_m_tready;

    assign optr_m1 = r_optr - OPW'(1);
    assign optr_m2 = r_optr - OPW'(2);
    assign optr_m3 = r_optr - OPW'(3);
    // Slot of the requested depth below the data stack top.
    assign d_idx   = 32'(r_dptr) - 32'd1 - i_s_tdata;

    assign int_res = (r_kind == OP_SUB) ? (r_top.value - op_rdata.value)
                                        : (r_top.value + op_rdata.value);

    tsm_ram #(.WIDTH(ENTRY_W), .DEPTH(OPERAND_DEPTH)) u_op_ram (
        .i_clk   (i_clk),
        .i_we    (op_we),
        .i_waddr (op_waddr),
        .i_wdata (op_wdata),
        .i_re    (op_re),
        .i_raddr (op_raddr),
        .o_rdata (op_rdata)
    );

    tsm_ram #(.WIDTH(ENTRY_W), .DEPTH(DATA_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (r_top),
        .i_re    (dm_re),
        .i_raddr (dm_raddr),
        .o_rdata (dm_rdata)
    );

    tsm_fadd u_fadd (
        .i_clk  (i_clk),
        .i_load (fp_load),
        .i_a    (r_top.value),
        .i_b    (op_rdata.value),
        .i_sub  (r_kind == OP_SUB),
        .o_sum  (fp_sum)
    );

    always_comb begin
        n_state  = r_state;
        n_optr   = r_optr;
        n_dptr   = r_dptr;
        n_halt   = r_halt;
        n_top    = r_top;
        n_status = ST_OK;
        done     = 1'b0;
        op_we    = 1'b0;
        op_waddr = r_optr[OAW-1:0];
        op_wdata = r_top;
        op_re    = 1'b0;
        op_raddr = optr_m2[OAW-1:0];
        dm_we    = 1'b0;
        dm_waddr = r_dptr[DAW-1:0];
        dm_re    = 1'b0;
        dm_raddr = d_idx[DAW-1:0];
        fp_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // Prefetch the entry below the top and the addressed data entry.
                if (accept) begin
                    op_re   = 1'b1;
                    dm_re   = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    done = 1'b1;
                    if (r_halt) begin
                        n_status = ST_HALTED;
                    end else begin
                        case (r_kind)
                            OP_PUSH: begin
                                if (r_itype == IMM_INT || r_itype == IMM_DEC) begin
                                    if (r_optr >= OPW'(OPERAND_DEPTH)) begin
                                        n_status = ST_FULL;
                                    end else begin
                                        n_top.ty    = (r_itype == IMM_INT) ? TY_INT : TY_DEC;
                                        n_top.value = r_ival;
                                        op_we    = 1'b1;
                                        op_wdata = n_top;
                                        n_optr   = r_optr + OPW'(1);
                                    end
                                end
                            end
                            OP_POP: begin
                                if (r_optr == '0) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    n_optr = optr_m1;
                                    n_top  = op_rdata;
                                end
                            end
                            OP_SAVE: begin
                                if (r_optr == '0) begin
                                    n_status = ST_EMPTY;
                                end else if (r_dptr >= DPW'(DATA_DEPTH)) begin
                                    n_status = ST_FULL;
                                end else begin
                                    dm_we  = 1'b1;
                                    n_dptr = r_dptr + DPW'(1);
                                    n_optr = optr_m1;
                                    n_top  = op_rdata;
                                end
                            end
                            OP_LOAD: begin
                                if (r_ival[31] || (r_ival >= 32'(r_dptr))) begin
                                    n_status = ST_INDEX;
                                end else if (r_optr >= OPW'(OPERAND_DEPTH)) begin
                                    n_status = ST_FULL;
                                end else begin
                                    op_we    = 1'b1;
                                    op_wdata = dm_rdata;
                                    n_top    = dm_rdata;
                                    n_optr   = r_optr + OPW'(1);
                                end
                            end
                            OP_ADD, OP_SUB: begin
                                if (r_optr < OPW'(2)) begin
                                    n_status = ST_EMPTY;
                                end else if (r_top.ty == TY_INT && op_rdata.ty == TY_INT) begin
                                    n_top.ty    = TY_INT;
                                    n_top.value = int_res;
                                    op_we    = 1'b1;
                                    op_waddr = optr_m2[OAW-1:0];
                                    op_wdata = n_top;
                                    n_optr   = optr_m1;
                                end else if (r_top.ty == TY_DEC && op_rdata.ty == TY_DEC) begin
                                    done    = 1'b0;
                                    fp_load = 1'b1;
                                    n_state = S_FP;
                                end else begin
                                    // Mismatched types drop both entries; fetch the new top.
                                    done     = 1'b0;
                                    n_optr   = optr_m2;
                                    op_re    = 1'b1;
                                    op_raddr = optr_m3[OAW-1:0];
                                    n_state  = S_RELOAD;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (n_status != ST_OK) begin
                            n_halt = 1'b1;
                        end
                    end
                    if (done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FP: begin
                if (out_free) begin
                    done        = 1'b1;
                    n_top.ty    = TY_DEC;
                    n_top.value = fp_sum;
                    op_we    = 1'b1;
                    op_waddr = optr_m2[OAW-1:0];
                    op_wdata = n_top;
                    n_optr   = optr_m1;
                    n_state  = S_IDLE;
                end
            end
            S_RELOAD: begin
                if (out_free) begin
                    done    = 1'b1;
                    n_top   = op_rdata;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_optr      <= '0;
            r_dptr      <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_optr  <= n_optr;
            r_dptr  <= n_dptr;
            r_halt  <= n_halt;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_s_tuser[2:0];
            r_itype <= i_s_tuser[4:3];
            r_ival  <= i_s_tdata;
        end
        r_top <= n_top;
        if (done) begin
            r_out_status <= n_status;
            r_out_type   <= (n_optr != '0) ? n_top.ty : TY_EMPTY;
            r_out_value  <= (n_optr != '0) ? n_top.value : 32'd0;
            r_out_ocnt   <= 7'(n_optr);
            r_out_dcnt   <= 7'(n_dptr);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_dcnt, r_out_ocnt, r_out_value, r_out_status};
    assign o_m_tuser  = r_out_type;

`ifndef ASSERT_OFF
    a_optr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_optr <= OPW'(OPERAND_DEPTH))
        else $error("operand pointer beyond stack depth");

    a_dptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dptr <= DPW'(DATA_DEPTH))
        else $error("data pointer beyond stack depth");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt cleared without reset");

    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> ($stable(r_optr) && $stable(r_dptr)))
        else $error("stack pointers moved while halted");
`endif

endmodule

// ----- src/tsm_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
module tsm_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tsm_fadd.sv -----
// Two-stage IEEE single adder: align and add into a register, then normalize and round.
module tsm_fadd
    import tsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_sub,
    output logic [31:0] o_sum
);

    // Stage one: operand unpack, swap, alignment and mantissa add.
    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swap, s_big, s_small;
    logic [7:0]  ea, eb, e_big, e_small, e_a, e_s, diff;
    logic [22:0] fa, fb, f_big, f_small;
    logic [4:0]  dc;
    logic [53:0] wide;
    logic [26:0] m_a, m_s;
    logic [27:0] sum;

    logic        r_nan, r_inf, r_inf_sign, r_sign, r_sub;
    logic [7:0]  r_exp;
    logic [27:0] r_sum;

    always_comb begin
        sa = i_a[31];
        sb = i_b[31] ^ i_sub;
        ea = i_a[30:23];
        eb = i_b[30:23];
        fa = i_a[22:0];
        fb = i_b[22:0];
        a_nan = (ea == 8'hFF) && (fa != 23'd0);
        b_nan = (eb == 8'hFF) && (fb != 23'd0);
        a_inf = (ea == 8'hFF) && (fa == 23'd0);
        b_inf = (eb == 8'hFF) && (fb == 23'd0);
        swap = {ea, fa} < {eb, fb};
        s_big   = swap ? sb : sa;
        s_small = swap ? sa : sb;
        e_big   = swap ? eb : ea;
        e_small = swap ? ea : eb;
        f_big   = swap ? fb : fa;
        f_small = swap ? fa : fb;
        e_a = (e_big == 8'd0) ? 8'd1 : e_big;
        e_s = (e_small == 8'd0) ? 8'd1 : e_small;
        diff = e_a - e_s;
        dc = (diff > 8'd27) ? 5'd27 : diff[4:0];
        wide = {(e_small != 8'd0), f_small, 3'b000, 27'd0} >> dc;
        m_s = wide[53:27] | {26'd0, (wide[26:0] != 27'd0)};
        m_a = {(e_big != 8'd0), f_big, 3'b000};
        if (s_big != s_small) begin
            sum = {1'b0, m_a} - {1'b0, m_s};
        end else begin
            sum = {1'b0, m_a} + {1'b0, m_s};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_nan      <= a_nan || b_nan || (a_inf && b_inf && (sa != sb));
            r_inf      <= a_inf || b_inf;
            r_inf_sign <= a_inf ? sa : sb;
            r_sign     <= s_big;
            r_sub      <= (s_big != s_small);
            r_exp      <= e_a;
            r_sum      <= sum;
        end
    end

    // Stage two: normalize (with a floor at the subnormal exponent) and round to nearest even.
    logic [4:0]  lz, sh;
    logic [26:0] m27;
    logic [9:0]  e, e_fin;
    logic [24:0] sig25;
    logic [23:0] sig;
    logic        rnd;

    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (r_sum[i]) begin
                lz = 5'(26 - i);
            end
        end
        sh = 5'd0;
        if (r_sum[27]) begin
            m27 = {r_sum[27:2], r_sum[1] | r_sum[0]};
            e = {2'b00, r_exp} + 10'd1;
        end else begin
            sh = ({3'b000, lz} < (r_exp - 8'd1)) ? lz : 5'((r_exp - 8'd1));
            m27 = r_sum[26:0] << sh;
            e = {2'b00, r_exp} - {5'd0, sh};
        end
        rnd = m27[2] && (m27[1] || m27[0] || m27[3]);
        sig25 = {1'b0, m27[26:3]} + {24'd0, rnd};
        if (sig25[24]) begin
            sig = sig25[24:1];
            e_fin = e + 10'd1;
        end else begin
            sig = sig25[23:0];
            e_fin = sig25[23] ? e : 10'd0;
        end

        if (r_nan) begin
            o_sum = FP_QNAN;
        end else if (r_inf) begin
            o_sum = {r_inf_sign, 8'hFF, 23'd0};
        end else if (r_sum == 28'd0) begin
            o_sum = {(r_sub ? 1'b0 : r_sign), 31'd0};
        end else if (e_fin >= 10'd255) begin
            o_sum = {r_sign, 8'hFF, 23'd0};
        end else begin
            o_sum = {r_sign, e_fin[7:0], sig[22:0]};
        end
    end

endmodule

// ----- dv/tb_typed_two_stack_machine_top.sv -----
// Self-checking testbench for typed_two_stack_machine_top with its own instruction predictor.
module tb_typed_two_stack_machine_top
    import tsm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_DEPTH   = 64;
    localparam int DAT_DEPTH  = 64;
    localparam int N_RANDOM   = 400;
    localparam int STALL_LIM  = 2000;
    localparam int HOLD_LEN   = 300;

    // One result item as the block reports it.
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  ty;
        logic [31:0] value;
        logic [6:0]  op_cnt;
        logic [6:0]  dat_cnt;
    } t_result;

    // One directed instruction; a typed row carries its expected result.
    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  imm_ty;
        logic [31:0] imm;
        logic        typed;
        t_result     want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // imm_value[31:0]
    logic [4:0]  i_s_tuser;   // kind[2:0], imm_type[4:3]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;   // status[2:0], top_value[34:3], operand_count[41:35],
                              // data_count[48:42], zero fill[55:49]
    logic [1:0]  o_m_tuser;   // top_type[1:0]

    typed_two_stack_machine_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Predicted machine state: both stacks, their depths and the sticky halt.
    t_entry  op_stk  [OP_DEPTH];
    t_entry  dat_stk [DAT_DEPTH];
    int      op_ptr;
    int      dat_ptr;
    bit      halted;

    t_result want_q[$];
    int      err_cnt;
    int      res_cnt;
    bit      idle_on;
    bit      hold_done;

    // Single precision add with round to nearest even on raw bits. The smaller operand is
    // aligned with 32 guard bits and a sticky bit, which keeps every rounding decision exact.
    function automatic logic [31:0] fp_addsub(logic [31:0] x, logic [31:0] y, bit sub);
        logic        sx, sy, sr, ts;
        int          ex, ey, e, d, p, ti;
        logic [63:0] mx, my, r, t;
        logic [24:0] keep;
        logic [31:0] rem;
        if (sub) begin
            y[31] = ~y[31];
        end
        sx = x[31];
        sy = y[31];
        ex = x[30:23];
        ey = y[30:23];
        if ((ex == 255 && x[22:0] != 0) || (ey == 255 && y[22:0] != 0)) begin
            return FP_QNAN;
        end
        if (ex == 255 && ey == 255) begin
            return (sx == sy) ? x : FP_QNAN;
        end
        if (ex == 255) begin
            return x;
        end
        if (ey == 255) begin
            return y;
        end
        mx = 64'({ex != 0, x[22:0]}) << 32;
        my = 64'({ey != 0, y[22:0]}) << 32;
        if (ex == 0) ex = 1;
        if (ey == 0) ey = 1;
        if (ey > ex || (ey == ex && my > mx)) begin
            ts = sx; sx = sy; sy = ts;
            ti = ex; ex = ey; ey = ti;
            t = mx; mx = my; my = t;
        end
        d = ex - ey;
        if (d >= 56) begin
            t = 64'(my != 0);
        end else begin
            t = my >> d;
            if ((t << d) != my) t[0] = 1'b1;
        end
        e  = ex;
        sr = sx;
        r  = (sx == sy) ? mx + t : mx - t;
        // An exact zero is positive unless both addends were negative zeros.
        if (r == 0) begin
            return {sx & sy, 31'd0};
        end
        p = 63;
        while (!r[p]) p--;
        if (p > 55) begin
            t = r >> (p - 55);
            if ((t << (p - 55)) != r) t[0] = 1'b1;
            r = t;
            e = e + p - 55;
        end else begin
            while (!r[55] && e > 1) begin
                r = r << 1;
                e--;
            end
        end
        keep = {1'b0, r[55:32]};
        rem  = r[31:0];
        if (rem > 32'h8000_0000 || (rem == 32'h8000_0000 && keep[0])) keep++;
        if (keep[24]) begin
            keep = keep >> 1;
            e++;
        end
        if (e >= 255) begin
            return {sr, 8'hFF, 23'd0};
        end
        if (!keep[23]) begin
            return {sr, 8'd0, keep[22:0]};
        end
        return {sr, 8'(e), keep[22:0]};
    endfunction

    // Executes one instruction on the predicted state and forms the result it answers with.
    task automatic tsm_execute(input logic [2:0] k, input logic [1:0] it,
                               input logic [31:0] v, output t_result r);
        logic [2:0] st;
        t_entry     a, b;
        st = ST_OK;
        if (halted) begin
            st = ST_HALTED;
        end else begin
            case (k)
                OP_PUSH: begin
                    // Only integer and single immediates push anything.
                    if (it == IMM_INT || it == IMM_DEC) begin
                        if (op_ptr >= OP_DEPTH) begin
                            st = ST_FULL;
                        end else begin
                            op_stk[op_ptr] = '{(it == IMM_INT) ? TY_INT : TY_DEC, v};
                            op_ptr++;
                        end
                    end
                end
                OP_POP: begin
                    if (op_ptr == 0) st = ST_EMPTY;
                    else op_ptr--;
                end
                OP_SAVE: begin
                    // An empty operand stack is reported before a full data stack.
                    if (op_ptr == 0) begin
                        st = ST_EMPTY;
                    end else if (dat_ptr >= DAT_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        dat_stk[dat_ptr] = op_stk[op_ptr - 1];
                        dat_ptr++;
                        op_ptr--;
                    end
                end
                OP_LOAD: begin
                    // The depth is signed: a negative depth is out of range.
                    if (v[31] || v >= 32'(dat_ptr)) begin
                        st = ST_INDEX;
                    end else if (op_ptr >= OP_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        op_stk[op_ptr] = dat_stk[dat_ptr - 1 - int'(v)];
                        op_ptr++;
                    end
                end
                OP_ADD, OP_SUB: begin
                    if (op_ptr < 2) begin
                        st = ST_EMPTY;
                    end else begin
                        a = op_stk[op_ptr - 1];
                        b = op_stk[op_ptr - 2];
                        op_ptr -= 2;
                        // Mixed types leave both entries popped and push nothing.
                        if (a.ty == TY_INT && b.ty == TY_INT) begin
                            op_stk[op_ptr] = '{TY_INT, (k == OP_SUB) ? a.value - b.value
                                                                     : a.value + b.value};
                            op_ptr++;
                        end else if (a.ty == TY_DEC && b.ty == TY_DEC) begin
                            op_stk[op_ptr] = '{TY_DEC, fp_addsub(a.value, b.value,
                                                                 k == OP_SUB)};
                            op_ptr++;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (st != ST_OK) halted = 1'b1;
        end
        r.status  = st;
        r.ty      = (op_ptr > 0) ? op_stk[op_ptr - 1].ty : TY_EMPTY;
        r.value   = (op_ptr > 0) ? op_stk[op_ptr - 1].value : 32'd0;
        r.op_cnt  = 7'(op_ptr);
        r.dat_cnt = 7'(dat_ptr);
    endtask

    // Offers one item, waits for it to be taken, then queues what it should answer.
    task automatic send_item(input logic [2:0] k, input logic [1:0] it, input logic [31:0] v,
                             input bit typed, input t_result want);
        t_result r;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = v;
        i_s_tuser  = {it, k};
        do @(posedge i_clk); while (!o_s_tready);
        tsm_execute(k, it, v, r);
        if (typed) r = want;
        want_q = {want_q, r};
    endtask

    task automatic push_one(input logic [1:0] it, input logic [31:0] v);
        send_item(OP_PUSH, it, v, 1'b0, '0);
    endtask

    // Float operands: often near one another so that subtraction cancels, sometimes tiny
    // or special.
    function automatic logic [31:0] rand_float();
        case ($urandom_range(0, 9))
            0:       return {1'($urandom), 8'd0, 23'($urandom)};
            1:       return {1'($urandom), 8'hFF, ($urandom_range(0, 1) != 0) ? 23'd0
                                                                           : 23'($urandom)};
            2:       return {1'($urandom), 31'd0};
            3, 4:    return $urandom;
            default: return {1'($urandom), 8'($urandom_range(124, 130)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rand_int();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(0, 20));
            default: return $urandom;
        endcase
    endfunction

    // Picks a legal instruction for the predicted state so that the run does not halt.
    task automatic send_random();
        int          c;
        logic [2:0]  k;
        logic [1:0]  it;
        logic [31:0] v;
        c  = $urandom_range(0, 99);
        it = 2'd0;
        v  = $urandom;
        if (c < 45 && op_ptr > 0 && op_ptr < OP_DEPTH - 1 && c >= 35) begin
            k = OP_POP;
        end else if (c >= 45 && c < 57 && op_ptr > 0 && dat_ptr < DAT_DEPTH) begin
            k = OP_SAVE;
        end else if (c >= 57 && c < 70 && dat_ptr > 0 && op_ptr < OP_DEPTH) begin
            k = OP_LOAD;
            v = ($urandom_range(0, 3) == 0) ? 32'(dat_ptr - 1)
                                            : 32'($urandom_range(0, dat_ptr - 1));
        end else if (c >= 70 && c < 92 && op_ptr >= 2) begin
            k = ($urandom_range(0, 1) != 0) ? OP_ADD : OP_SUB;
        end else if (c >= 92) begin
            k = ($urandom_range(0, 1) != 0) ? OP_NONE : 3'd7;
        end else if (op_ptr < OP_DEPTH) begin
            k = OP_PUSH;
            c = $urandom_range(0, 19);
            if (c < 9) begin
                it = IMM_INT;
                v  = rand_int();
            end else if (c < 18) begin
                it = IMM_DEC;
                v  = rand_float();
            end else begin
                it = (c == 18) ? 2'd0 : 2'd3;
            end
        end else begin
            k = OP_POP;
        end
        send_item(k, it, v, 1'b0, '0);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch in %s at result %0d: got %h, expected %h", what, res_cnt, got, exp);
        err_cnt++;
    endtask

    // Results are compared at the rising edge on which they are handed over.
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (want_q.size() == 0) begin
                report("unexpected result", o_m_tdata[31:0], 32'd0);
            end else begin
                w = want_q.pop_front();
                if (o_m_tdata[2:0] != w.status)    report("status", o_m_tdata[2:0], w.status);
                if (o_m_tuser != w.ty)             report("top type", o_m_tuser, w.ty);
                if (o_m_tdata[34:3] != w.value)    report("top value", o_m_tdata[34:3], w.value);
                if (o_m_tdata[41:35] != w.op_cnt)  report("operand count", o_m_tdata[41:35],
                                                          w.op_cnt);
                if (o_m_tdata[48:42] != w.dat_cnt) report("data count", o_m_tdata[48:42],
                                                          w.dat_cnt);
                if (o_m_tdata[55:49] != 7'd0)      report("fill bits", o_m_tdata[55:49], 0);
            end
            res_cnt++;
        end
    end

    // The receiver stalls in short bursts, and once for a long stretch so that the block
    // backs up and holds off the sender.
    initial begin
        i_m_tready = 1'b1;
        hold_done  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && res_cnt >= 150) begin
                i_m_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_done = 1'b1;
                i_m_tready = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // Ends the run when nothing moves on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIM) begin
                $display("typed_two_stack_machine_top test failed");
                $finish;
            end
        end
    end

    // Directed program: integer wrap, infinities giving NaN, mixed types, ignored pushes and
    // opcodes, subnormal and largest singles, float overflow, store and load at both ends.
    t_row dir_rows [] = '{
        '{OP_NONE,  2'd0,    32'd0,          1'b1, '{ST_OK, TY_EMPTY, 32'd0, 7'd0, 7'd0}},
        '{OP_PUSH,  IMM_INT, 32'h7FFF_FFFF,  1'b1, '{ST_OK, TY_INT, 32'h7FFF_FFFF, 7'd1, 7'd0}},
        '{OP_PUSH,  IMM_INT, 32'h0000_0001,  1'b1, '{ST_OK, TY_INT, 32'h0000_0001, 7'd2, 7'd0}},
        '{OP_ADD,   2'd0,    32'd0,          1'b1, '{ST_OK, TY_INT, 32'h8000_0000, 7'd1, 7'd0}},
        '{OP_PUSH,  IMM_INT, 32'hFFFF_FFFF,  1'b1, '{ST_OK, TY_INT, 32'hFFFF_FFFF, 7'd2, 7'd0}},
        '{OP_SUB,   2'd0,    32'd0,          1'b1, '{ST_OK, TY_INT, 32'h7FFF_FFFF, 7'd1, 7'd0}},
        '{OP_PUSH,  IMM_DEC, 32'h7F80_0000,  1'b0, '0},
        '{OP_PUSH,  IMM_DEC, 32'hFF80_0000,  1'b0, '0},
        '{OP_ADD,   2'd0,    32'd0,          1'b1, '{ST_OK, TY_DEC, FP_QNAN, 7'd2, 7'd0}},
        '{OP_ADD,   2'd0,    32'd0,          1'b1, '{ST_OK, TY_EMPTY, 32'd0, 7'd0, 7'd0}},
        '{OP_PUSH,  2'd0,    32'hFFFF_FFFF,  1'b1, '{ST_OK, TY_EMPTY, 32'd0, 7'd0, 7'd0}},
        '{OP_PUSH,  2'd3,    32'h1234_5678,  1'b1, '{ST_OK, TY_EMPTY, 32'd0, 7'd0, 7'd0}},
        '{3'd7,     2'd3,    32'hFFFF_FFFF,  1'b1, '{ST_OK, TY_EMPTY, 32'd0, 7'd0, 7'd0}},
        '{OP_PUSH,  IMM_DEC, 32'h3F80_0000,  1'b0, '0},
        '{OP_PUSH,  IMM_DEC, 32'h0000_0001,  1'b0, '0},
        '{OP_SUB,   2'd0,    32'd0,          1'b0, '0},
        '{OP_SAVE,  2'd0,    32'd0,          1'b0, '0},
        '{OP_PUSH,  IMM_DEC, 32'h7F7F_FFFF,  1'b0, '0},
        '{OP_SAVE,  2'd0,    32'd0,          1'b0, '0},
        '{OP_LOAD,  2'd0,    32'd0,          1'b0, '0},
        '{OP_LOAD,  2'd0,    32'd1,          1'b0, '0},
        '{OP_ADD,   2'd0,    32'd0,          1'b0, '0},
        '{OP_PUSH,  IMM_DEC, 32'h7F7F_FFFF,  1'b0, '0},
        '{OP_ADD,   2'd0,    32'd0,          1'b0, '0},
        '{OP_POP,   2'd0,    32'd0,          1'b0, '0}
    };

    initial begin
        int n;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 32'd0;
        i_s_tuser  = 5'd0;
        op_ptr     = 0;
        dat_ptr    = 0;
        halted     = 1'b0;
        err_cnt    = 0;
        res_cnt    = 0;
        idle_on    = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].kind, dir_rows[i].imm_ty, dir_rows[i].imm,
                      dir_rows[i].typed, dir_rows[i].want);
        end

        // Random legal program; idling switches on and off in stretches of 50 items.
        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_random();
        end

        // The last part runs without idling. Exactly one error is provoked, since the halt
        // it sets is sticky; the seed decides which.
        idle_on = 1'b0;
        case ($urandom_range(0, 4))
            0: begin
                while (op_ptr > 0) send_item(OP_POP, 2'd0, $urandom, 1'b0, '0);
                send_item(OP_POP, 2'd0, $urandom, 1'b0, '0);
            end
            1: begin
                while (op_ptr > 1) send_item(OP_POP, 2'd0, $urandom, 1'b0, '0);
                send_item(($urandom_range(0, 1) != 0) ? OP_ADD : OP_SUB, 2'd0, 32'd0,
                          1'b0, '0);
            end
            2: begin
                send_item(OP_LOAD, 2'd0, ($urandom_range(0, 1) != 0)
                          ? 32'(dat_ptr) + 32'($urandom_range(0, 3))
                          : {1'b1, 31'($urandom)}, 1'b0, '0);
            end
            3: begin
                while (op_ptr < OP_DEPTH) push_one(IMM_INT, $urandom);
                if (dat_ptr > 0 && $urandom_range(0, 1) != 0)
                    send_item(OP_LOAD, 2'd0, 32'd0, 1'b0, '0);
                else
                    push_one(IMM_DEC, $urandom);
            end
            default: begin
                while (dat_ptr < DAT_DEPTH) begin
                    if (op_ptr == 0) push_one(IMM_INT, $urandom);
                    send_item(OP_SAVE, 2'd0, 32'd0, 1'b0, '0);
                end
                if (op_ptr == 0) push_one(IMM_DEC, $urandom);
                send_item(OP_SAVE, 2'd0, 32'd0, 1'b0, '0);
            end
        endcase
        repeat (20) send_item(3'($urandom), 2'($urandom), $urandom, 1'b0, '0);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;

        while (want_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("typed_two_stack_machine_top test passed");
        end else begin
            $display("typed_two_stack_machine_top test failed");
        end
        $finish;
    end

endmodule
